// ----- src/lim_pkg.sv -----
// Shared constants and controller/datapath interface types for the layer index map builder.
`default_nettype none
package lim_pkg;

	localparam int MAX_LAYERS    = 64;
	localparam int LAYER_AW      = $clog2(MAX_LAYERS);
	localparam int CNT_W         = LAYER_AW + 1;
	localparam int SUBSYSTEM_IDS = 16;
	localparam int SUB_W         = $clog2(SUBSYSTEM_IDS);
	localparam int RANK_W        = SUB_W;
	localparam int RANK_CW       = RANK_W + 1;
	localparam int LOC_W         = 6;
	localparam int SPAN_W        = LOC_W + 1;
	localparam int TABLE_SLOTS   = 64;
	localparam int SLOT_AW       = $clog2(TABLE_SLOTS);
	localparam int BASE_W        = SPAN_W + SUB_W;
	localparam int BASE_DEPTH    = SUBSYSTEM_IDS + 1;

	typedef logic [CNT_W-1:0] cnt_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // store the input layer being transferred
		logic scan_issue;  // read a stored layer for the span pass
		logic prefix_step; // add one span into the base offsets
		logic check;       // latch total slot count
		logic fill_issue;  // read a stored layer for the table fill
		logic em_rd;       // read one table slot, advance owning rank
		logic em_ld;       // load the output register with that slot
		logic err_ld;      // load the output register with the error result
		logic clear;       // return counts, flags, spans and base offsets to their reset values
		cnt_t idx;         // layer, rank or slot index of the current step
	} lim_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cnt_t               cnt;      // stored layer count
		logic [RANK_CW-1:0] rank_cnt; // ranks handed out
		logic               bad;      // overflow seen or table too large
		logic               out_fire; // output transfer at this edge
		logic               out_last; // held result is the last of the run
	} lim_sts_t;

endpackage
`default_nettype wire

// ----- src/lim_ctrl.sv -----
// Sequencer for load, span scan, prefix sum, check, table fill, emission and clear.
`default_nettype none
module lim_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              last_layer,
	output logic                   in_ready,
	input  wire lim_pkg::lim_sts_t sts,
	output lim_pkg::lim_cmd_t      cmd
);

	localparam logic [3:0] ST_LOAD   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_PREFIX = 4'd2;
	localparam logic [3:0] ST_CHECK  = 4'd3;
	localparam logic [3:0] ST_FILL   = 4'd4;
	localparam logic [3:0] ST_EM_RD  = 4'd5;
	localparam logic [3:0] ST_EM_LD  = 4'd6;
	localparam logic [3:0] ST_EM_WT  = 4'd7;
	localparam logic [3:0] ST_CLEAR  = 4'd8;

	logic [3:0]    state_q, state_d;
	lim_pkg::cnt_t idx_q, idx_d;
	logic          in_fire;
	logic          scan_more, prefix_more;

	assign in_ready    = (state_q == ST_LOAD);
	assign in_fire     = in_valid & in_ready;
	assign scan_more   = (idx_q != sts.cnt);
	assign prefix_more = (idx_q != lim_pkg::CNT_W'(sts.rank_cnt));

	always_comb begin
		state_d         = state_q;
		idx_d           = idx_q;
		cmd             = '0;
		cmd.idx         = idx_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd.load = in_fire;
				if (in_fire && last_layer) begin
					state_d = ST_SCAN;
					idx_d   = '0;
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = scan_more;
				if (scan_more) begin
					idx_d = idx_q + lim_pkg::CNT_W'(1);
				end else begin
					state_d = ST_PREFIX;
					idx_d   = '0;
				end
			end
			ST_PREFIX: begin
				cmd.prefix_step = prefix_more;
				if (prefix_more) begin
					idx_d = idx_q + lim_pkg::CNT_W'(1);
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				idx_d     = '0;
				if (sts.bad) begin
					cmd.err_ld = 1'b1;
					state_d    = ST_EM_WT;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_issue = scan_more;
				if (scan_more) begin
					idx_d = idx_q + lim_pkg::CNT_W'(1);
				end else begin
					state_d = ST_EM_RD;
					idx_d   = '0;
				end
			end
			ST_EM_RD: begin
				cmd.em_rd = 1'b1;
				state_d   = ST_EM_LD;
			end
			ST_EM_LD: begin
				cmd.em_ld = 1'b1;
				state_d   = ST_EM_WT;
			end
			ST_EM_WT: begin
				if (sts.out_fire) begin
					if (sts.out_last) begin
						state_d = ST_CLEAR;
					end else begin
						idx_d   = idx_q + lim_pkg::CNT_W'(1);
						state_d = ST_EM_RD;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule
`default_nettype wire

// ----- src/lim_datapath.sv -----
// Layer store, rank tables, spans, base offsets, slot table and output register.
`default_nettype none
module lim_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lim_pkg::lim_cmd_t             cmd,
	output lim_pkg::lim_sts_t                  sts,
	input  wire logic [lim_pkg::SUB_W-1:0]     subsystem_id,
	input  wire logic [lim_pkg::LOC_W-1:0]     local_layer,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [lim_pkg::SLOT_AW-1:0]        slot_index,
	output logic [lim_pkg::SUB_W-1:0]          subsystem_out,
	output logic [lim_pkg::RANK_W-1:0]         subsystem_rank,
	output logic [lim_pkg::LOC_W-1:0]          local_out,
	output logic [lim_pkg::LAYER_AW-1:0]       global_layer,
	output logic                               mapped,
	output logic                               overflow_error,
	output logic                               last_result
);

	localparam int SUB_W   = lim_pkg::SUB_W;
	localparam int LOC_W   = lim_pkg::LOC_W;
	localparam int RANK_W  = lim_pkg::RANK_W;
	localparam int RANK_CW = lim_pkg::RANK_CW;
	localparam int SPAN_W  = lim_pkg::SPAN_W;
	localparam int BASE_W  = lim_pkg::BASE_W;
	localparam int LAW     = lim_pkg::LAYER_AW;
	localparam int SAW     = lim_pkg::SLOT_AW;
	localparam int NSUB    = lim_pkg::SUBSYSTEM_IDS;

	// Memories: stored layers and slot contents.
	logic [SUB_W+LOC_W-1:0] layer_mem [lim_pkg::MAX_LAYERS];
	logic [LAW-1:0]         slot_mem  [lim_pkg::TABLE_SLOTS];

	lim_pkg::cnt_t      cnt_q;
	logic               ovf_q;
	logic [NSUB-1:0]    assigned_q;
	logic [RANK_W-1:0]  rank_of_q [NSUB];
	logic [SUB_W-1:0]   sub_of_q  [NSUB];
	logic [RANK_CW-1:0] rank_cnt_q;
	logic [SPAN_W-1:0]  span_q [NSUB];
	logic [BASE_W-1:0]  base_q [lim_pkg::BASE_DEPTH];
	logic [lim_pkg::TABLE_SLOTS-1:0] slot_vld_q;
	logic [BASE_W-1:0]  total_q;
	logic [RANK_W-1:0]  erank_q;

	logic               scan_v_s1, fill_v_s1;
	logic [SUB_W-1:0]   rd_sub_s1;
	logic [LOC_W-1:0]   rd_loc_s1;
	logic [LAW-1:0]     rd_idx_s1;
	logic [LAW-1:0]     slot_rd_s1;
	logic               slot_map_s1;

	logic               out_valid_q;
	logic [SAW-1:0]     slot_index_q;
	logic [SUB_W-1:0]   subsystem_out_q;
	logic [RANK_W-1:0]  subsystem_rank_q;
	logic [LOC_W-1:0]   local_out_q;
	logic [LAW-1:0]     global_layer_q;
	logic               mapped_q, overflow_error_q, last_result_q;

	logic [SUB_W-1:0]   rank_addr;
	logic [RANK_W-1:0]  rank_rd;
	logic [RANK_W-1:0]  span_addr;
	logic [SPAN_W-1:0]  span_rd;
	logic [SPAN_W-1:0]  loc_p1;
	logic [RANK_CW-1:0] base_addr;
	logic [BASE_W-1:0]  base_rd;
	logic [BASE_W-1:0]  fill_slot;
	logic [BASE_W-1:0]  idx_w;
	logic               new_rank;
	logic               out_fire;

	assign rank_addr = cmd.load ? subsystem_id : rd_sub_s1;
	assign rank_rd   = rank_of_q[rank_addr];
	assign span_addr = scan_v_s1 ? rank_rd : cmd.idx[RANK_W-1:0];
	assign span_rd   = span_q[span_addr];
	assign loc_p1    = SPAN_W'(rd_loc_s1) + SPAN_W'(1);
	assign idx_w     = BASE_W'(cmd.idx);

	// One read port on the base offsets, steered by the active step.
	always_comb begin
		if (fill_v_s1) begin
			base_addr = RANK_CW'(rank_rd);
		end else if (cmd.em_rd) begin
			base_addr = RANK_CW'(erank_q) + RANK_CW'(1);
		end else if (cmd.em_ld) begin
			base_addr = RANK_CW'(erank_q);
		end else if (cmd.check) begin
			base_addr = rank_cnt_q;
		end else begin
			base_addr = cmd.idx[RANK_CW-1:0];
		end
	end
	assign base_rd   = base_q[base_addr];
	assign fill_slot = base_rd + BASE_W'(rd_loc_s1);

	assign new_rank = cmd.load && (cnt_q < lim_pkg::CNT_W'(lim_pkg::MAX_LAYERS))
		&& !assigned_q[subsystem_id] && (rank_cnt_q != RANK_CW'(NSUB));
	assign out_fire = out_valid_q & out_ready;

	assign sts.cnt      = cnt_q;
	assign sts.rank_cnt = rank_cnt_q;
	assign sts.bad      = ovf_q | (base_rd > BASE_W'(lim_pkg::TABLE_SLOTS));
	assign sts.out_fire = out_fire;
	assign sts.out_last = last_result_q;

	// Layer store: write on load, registered read for scan and fill.
	always_ff @(posedge clk) begin
		if (cmd.load && (cnt_q < lim_pkg::CNT_W'(lim_pkg::MAX_LAYERS))) begin
			layer_mem[cnt_q[LAW-1:0]] <= {subsystem_id, local_layer};
		end
		if (cmd.scan_issue || cmd.fill_issue) begin
			{rd_sub_s1, rd_loc_s1} <= layer_mem[cmd.idx[LAW-1:0]];
			rd_idx_s1              <= cmd.idx[LAW-1:0];
		end
	end

	// Slot table contents: written in fill, read during emission.
	always_ff @(posedge clk) begin
		if (fill_v_s1 && (fill_slot < BASE_W'(lim_pkg::TABLE_SLOTS))) begin
			slot_mem[fill_slot[SAW-1:0]] <= rd_idx_s1;
		end
		if (cmd.em_rd) begin
			slot_rd_s1  <= slot_mem[cmd.idx[SAW-1:0]];
			slot_map_s1 <= slot_vld_q[cmd.idx[SAW-1:0]];
		end
	end

	// Rank tables are read only below the rank count, so they need no reset.
	always_ff @(posedge clk) begin
		if (new_rank) begin
			rank_of_q[subsystem_id]          <= rank_cnt_q[RANK_W-1:0];
			sub_of_q[rank_cnt_q[RANK_W-1:0]] <= subsystem_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			assigned_q <= '0;
			rank_cnt_q <= '0;
			slot_vld_q <= '0;
			scan_v_s1  <= 1'b0;
			fill_v_s1  <= 1'b0;
			erank_q    <= '0;
			total_q    <= '0;
			for (int i = 0; i < NSUB; i++) begin
				span_q[i] <= '0;
			end
			for (int i = 0; i < lim_pkg::BASE_DEPTH; i++) begin
				base_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			assigned_q <= '0;
			rank_cnt_q <= '0;
			slot_vld_q <= '0;
			scan_v_s1  <= 1'b0;
			fill_v_s1  <= 1'b0;
			for (int i = 0; i < NSUB; i++) begin
				span_q[i] <= '0;
			end
			for (int i = 0; i < lim_pkg::BASE_DEPTH; i++) begin
				base_q[i] <= '0;
			end
		end else begin
			scan_v_s1 <= cmd.scan_issue;
			fill_v_s1 <= cmd.fill_issue;
			if (cmd.load) begin
				if (cnt_q < lim_pkg::CNT_W'(lim_pkg::MAX_LAYERS)) begin
					cnt_q <= cnt_q + lim_pkg::CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (new_rank) begin
				assigned_q[subsystem_id] <= 1'b1;
				rank_cnt_q               <= rank_cnt_q + RANK_CW'(1);
			end
			if (scan_v_s1 && (loc_p1 > span_rd)) begin
				span_q[rank_rd] <= loc_p1;
			end
			if (cmd.prefix_step) begin
				base_q[cmd.idx[RANK_CW-1:0] + RANK_CW'(1)] <= base_rd + BASE_W'(span_rd);
			end
			if (cmd.check) begin
				total_q <= base_rd;
				erank_q <= '0;
			end
			if (fill_v_s1 && (fill_slot < BASE_W'(lim_pkg::TABLE_SLOTS))) begin
				slot_vld_q[fill_slot[SAW-1:0]] <= 1'b1;
			end
			// Step to the next rank when the slot reaches its upper bound.
			if (cmd.em_rd && (idx_w == base_rd)) begin
				erank_q <= erank_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.em_ld || cmd.err_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err_ld) begin
			slot_index_q     <= '0;
			subsystem_out_q  <= '0;
			subsystem_rank_q <= '0;
			local_out_q      <= '0;
			global_layer_q   <= '0;
			mapped_q         <= 1'b0;
			overflow_error_q <= 1'b1;
			last_result_q    <= 1'b1;
		end else if (cmd.em_ld) begin
			slot_index_q     <= cmd.idx[SAW-1:0];
			subsystem_out_q  <= sub_of_q[erank_q];
			subsystem_rank_q <= erank_q;
			local_out_q      <= LOC_W'(idx_w - base_rd);
			global_layer_q   <= slot_map_s1 ? slot_rd_s1 : '0;
			mapped_q         <= slot_map_s1;
			overflow_error_q <= 1'b0;
			last_result_q    <= ((idx_w + BASE_W'(1)) == total_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign slot_index     = slot_index_q;
	assign subsystem_out  = subsystem_out_q;
	assign subsystem_rank = subsystem_rank_q;
	assign local_out      = local_out_q;
	assign global_layer   = global_layer_q;
	assign mapped         = mapped_q;
	assign overflow_error = overflow_error_q;
	assign last_result    = last_result_q;

endmodule
`default_nettype wire

// ----- src/layer_index_map_builder.sv -----
// Top level of the layer index map builder: controller plus datapath.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------------------
//   in      | in_valid / in_ready   | subsystem_id, local_layer, last_layer
//   out     | out_valid / out_ready | slot_index .. last_result, eight fields per slot
//
// A layer without the last mark is one write into the layer store.
// The last layer starts the build: a scan over the L stored layers, a prefix pass over
// the R ranks, a check, a fill over the L layers, a read, a load and a wait per table
// slot and a clear; an error run presents its single result right after the check.
// Reset clears all control state and every store that has a reset value at once.
// in_ready stays low from the last layer through the clear cycle; a stalled out_ready
// holds the result and pauses the emission walk.
`default_nettype none
module layer_index_map_builder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [lim_pkg::SUB_W-1:0]      subsystem_id,
	input  wire logic [lim_pkg::LOC_W-1:0]      local_layer,
	input  wire logic                           last_layer,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [lim_pkg::SLOT_AW-1:0]         slot_index,
	output logic [lim_pkg::SUB_W-1:0]           subsystem_out,
	output logic [lim_pkg::RANK_W-1:0]          subsystem_rank,
	output logic [lim_pkg::LOC_W-1:0]           local_out,
	output logic [lim_pkg::LAYER_AW-1:0]        global_layer,
	output logic                                mapped,
	output logic                                overflow_error,
	output logic                                last_result
);

	// Commands down to the datapath, status back to the sequencer.
	lim_pkg::lim_cmd_t cmd;
	lim_pkg::lim_sts_t sts;

	// Sequence the phases and own the step index.
	lim_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_layer (last_layer),
		.in_ready   (in_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Hold the stores and the output register; drive the result payload.
	lim_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.subsystem_id   (subsystem_id),
		.local_layer    (local_layer),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.slot_index     (slot_index),
		.subsystem_out  (subsystem_out),
		.subsystem_rank (subsystem_rank),
		.local_out      (local_out),
		.global_layer   (global_layer),
		.mapped         (mapped),
		.overflow_error (overflow_error),
		.last_result    (last_result)
	);

endmodule
`default_nettype wire

// ----- src/lim_checker.sv -----
// Port-level assertions for the layer index map builder and their bind.
`default_nettype none
module lim_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic [lim_pkg::SUB_W-1:0]      subsystem_id,
	input wire logic [lim_pkg::LOC_W-1:0]      local_layer,
	input wire logic                           last_layer,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [lim_pkg::SLOT_AW-1:0]    slot_index,
	input wire logic [lim_pkg::SUB_W-1:0]      subsystem_out,
	input wire logic [lim_pkg::RANK_W-1:0]     subsystem_rank,
	input wire logic [lim_pkg::LOC_W-1:0]      local_out,
	input wire logic [lim_pkg::LAYER_AW-1:0]   global_layer,
	input wire logic                           mapped,
	input wire logic                           overflow_error,
	input wire logic                           last_result
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_index)
			&& $stable(global_layer) && $stable(last_result))
		else $error("stalled result changed");

	// No layer is taken while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready during emission");

	// The error result ends the run and carries nothing else.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_error |-> last_result && !mapped
			&& (slot_index == '0) && (global_layer == '0))
		else $error("malformed error result");

	// Unmapped slots report global index zero.
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mapped |-> (global_layer == '0))
		else $error("unmapped slot with nonzero global index");

	// After the final transfer no result follows at once.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_result |=> !out_valid)
		else $error("result after last of run");

endmodule

bind layer_index_map_builder lim_checker u_lim_checker (.*);
`default_nettype wire
